FILE: rtl/ultrasonic_ranger_tone_unit_assert.svh
// Assertion macros shared by the ranger RTL modules.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ULTRASONIC_RANGER_TONE_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGER_TONE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define URT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define URT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/urt_pkg.sv
// Package for the ultrasonic ranger tone unit: constants, payload types and
// the band and half-period lookups. No dependencies.
package urt_pkg;

  localparam int unsigned TONE_PRESCALE = 8;
  localparam int unsigned PRESCALE_W = (TONE_PRESCALE > 1) ? $clog2(TONE_PRESCALE) : 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TICKS    = 2'd2;

  localparam logic [15:0] TRIGGER_TICKS_RST = 16'd20;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd45000;
  localparam logic [13:0] BAND_TICKS_RST    = 14'd1500;
  localparam logic [2:0]  NOTE_BAND_RST     = 3'd7;
  localparam logic [2:0]  NOTE_BAND_MAX     = 3'd7;

  typedef struct packed {
    logic [15:0] trigger_ticks;
    logic [15:0] timeout_ticks;
    logic [13:0] band_ticks;
  } cfg_t;

  typedef struct packed {
    logic        trigger_out;
    logic        width_valid;
    logic [15:0] echo_width;
    logic [2:0]  note_index;
    logic        timed_out;
  } ctrl_res_t;

  typedef struct packed {
    logic        trigger_out;
    logic        tone_out;
    logic        width_valid;
    logic [15:0] echo_width;
    logic [2:0]  note_index;
    logic        timed_out;
  } out_item_t;

  // Tone half period in prescaled ticks for each note band.
  function automatic logic [6:0] tone_half_ticks(input logic [2:0] band);
    logic [6:0] hp;
    case (band)
      3'd0:    hp = 7'd119;
      3'd1:    hp = 7'd105;
      3'd2:    hp = 7'd94;
      3'd3:    hp = 7'd88;
      3'd4:    hp = 7'd79;
      3'd5:    hp = 7'd70;
      3'd6:    hp = 7'd62;
      default: hp = 7'd59;
    endcase
    return hp;
  endfunction

  // Band of an echo width: the number of band boundaries the width reaches,
  // capped at the farthest band. A zero span counts as one tick.
  function automatic logic [2:0] band_of(input logic [15:0] width,
                                         input logic [13:0] span);
    logic [13:0] span_eff;
    logic [16:0] thr;
    logic [2:0]  cnt;
    span_eff = (span == 14'd0) ? 14'd1 : span;
    cnt = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      thr = 17'(span_eff) * 17'(k);
      if ({1'b0, width} >= thr) begin
        cnt = cnt + 3'd1;
      end
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/urt_if.sv
// Valid/ready stream interfaces for the ranger input ticks and results.
// Does not depend on urt_pkg; payload fields are plain logic.
interface urt_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface urt_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_out;
  logic        tone_out;
  logic        width_valid;
  logic [15:0] echo_width;
  logic [2:0]  note_index;
  logic        timed_out;

  modport source (output valid, output trigger_out, output tone_out, output width_valid,
                  output echo_width, output note_index, output timed_out, input ready);
  modport sink   (input valid, input trigger_out, input tone_out, input width_valid,
                  input echo_width, input note_index, input timed_out, output ready);
endinterface

FILE: rtl/urt_ctrl.sv
// Ranging sequencer: trigger pulse, listen window, echo width count and band.
// Depends on urt_pkg and the assertion macro header.
module urt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              echo_i,
  input  urt_pkg::cfg_t     cfg_i,
  output urt_pkg::ctrl_res_t res_o,
  output logic [2:0]        band_o
);
  import urt_pkg::*;

  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_LISTEN  = 2'd1;
  localparam logic [1:0] PH_MEASURE = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] since_trig_q, since_trig_d;
  logic [15:0] since_rise_q, since_rise_d;
  logic        last_echo_q;
  logic [2:0]  band_q, band_d;

  logic [15:0] trig_inc;
  logic [15:0] rise_inc;
  logic        rise, fall, done;

  assign trig_inc = since_trig_q + 16'd1;
  assign rise_inc = since_rise_q + 16'd1;
  assign rise = echo_i & ~last_echo_q;
  assign fall = ~echo_i & last_echo_q;

  always_comb begin
    phase_d      = phase_q;
    since_trig_d = trig_inc;
    since_rise_d = since_rise_q;
    band_d       = band_q;
    done         = 1'b0;
    res_o        = '0;
    res_o.trigger_out = (phase_q == PH_TRIGGER);

    case (phase_q)
      PH_LISTEN, PH_MEASURE: begin
        if (phase_q == PH_MEASURE) begin
          since_rise_d = rise_inc;
          if (fall) begin
            res_o.width_valid = 1'b1;
            res_o.echo_width  = rise_inc;
            band_d            = band_of(rise_inc, cfg_i.band_ticks);
            phase_d           = PH_TRIGGER;
            since_trig_d      = '0;
            done              = 1'b1;
          end
        end else if (rise) begin
          phase_d      = PH_MEASURE;
          since_rise_d = '0;
        end
        // A falling edge on the last listening tick takes precedence.
        if (!done && (trig_inc >= cfg_i.timeout_ticks)) begin
          res_o.timed_out = 1'b1;
          phase_d         = PH_TRIGGER;
          since_trig_d    = '0;
        end
      end
      default: begin
        if (trig_inc >= cfg_i.trigger_ticks) begin
          phase_d      = PH_LISTEN;
          since_trig_d = '0;
        end
      end
    endcase

    res_o.note_index = band_d;
  end

  assign band_o = band_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TRIGGER;
      since_trig_q <= '0;
      since_rise_q <= '0;
      last_echo_q  <= 1'b0;
      band_q       <= NOTE_BAND_RST;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      since_trig_q <= since_trig_d;
      since_rise_q <= since_rise_d;
      last_echo_q  <= echo_i;
      band_q       <= band_d;
    end
  end

`include "ultrasonic_ranger_tone_unit_assert.svh"

  `URT_ASSERT_IMP(a_fall_beats_timeout, res_o.width_valid, !res_o.timed_out, "timeout with width")
  `URT_ASSERT_NXT(a_width_retriggers, fire_i && res_o.width_valid, phase_q == PH_TRIGGER, "no retrigger after width")
  `URT_ASSERT_NXT(a_timeout_retriggers, fire_i && res_o.timed_out, phase_q == PH_TRIGGER && since_trig_q == 16'd0, "no retrigger after timeout")
  `URT_ASSERT_IMP(a_width_only_when_valid, !res_o.width_valid, res_o.echo_width == 16'd0, "stray width value")

endmodule

FILE: rtl/urt_tone.sv
// Square-wave tone generator: a prescaler and a half-period counter set by the band.
// Depends on urt_pkg.
module urt_tone (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [2:0] band_i,
  output logic       tone_o
);
  import urt_pkg::*;

  localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TONE_PRESCALE - 1);

  logic [PRESCALE_W-1:0] pre_q, pre_d;
  logic [6:0]            cnt_q, cnt_d;
  logic                  lvl_q, lvl_d;

  always_comb begin
    pre_d = pre_q + PRESCALE_W'(1);
    cnt_d = cnt_q;
    lvl_d = lvl_q;
    if (pre_q == PRESCALE_LAST) begin
      pre_d = '0;
      // A count already at or past a shorter new half period flips at the next prescaler wrap.
      if (cnt_q >= tone_half_ticks(band_i)) begin
        cnt_d = '0;
        lvl_d = ~lvl_q;
      end else begin
        cnt_d = cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      cnt_q <= '0;
      lvl_q <= 1'b0;
    end else if (fire_i) begin
      pre_q <= pre_d;
      cnt_q <= cnt_d;
      lvl_q <= lvl_d;
    end
  end

  assign tone_o = lvl_q;

endmodule

FILE: rtl/ultrasonic_ranger_tone_unit.sv
// Top level of the ultrasonic ranger with tone output.
// Depends on urt_pkg, urt_if, urt_ctrl, urt_tone and the assertion macro header.
//
// Usage: every transfer on in_i is one timer tick carrying the sampled echo
// pin level. Every tick produces exactly one result transfer on out_o with
// the trigger drive and speaker level at the start of that tick, a finished
// echo width with its valid flag, the note band after the tick and a timeout
// flag. The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the
// trigger length, the listen timeout and the band span; an unknown index is
// dropped. Write it only while no tick is in flight.
// A tick accepted into the input register is processed once the result
// register is free, and its result then waits there until out_o takes it.
// Throughput: one tick per cycle while out_o is not stalled; the sequencer
// and tone state update between the input register and result register.
// Reset puts the sequencer in the trigger phase with all counters at zero,
// the note band at the farthest band and the configuration at its defaults.
// When the receiver stalls, the held result keeps its value, one more tick
// waits in the input register, and in_i.ready then drops until out_o moves.
module ultrasonic_ranger_tone_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  urt_in_if.sink                            in_i,
  urt_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [urt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [urt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import urt_pkg::*;

  // Configuration registers, loaded straight from the write port.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TRIGGER_TICKS_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg_q.band_ticks    <= BAND_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_wdata_i;
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata_i;
        REG_BAND_TICKS:    cfg_q.band_ticks    <= cfg_wdata_i[13:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: holds one accepted tick until the result register is free.
  logic in_vld_q;
  logic echo_q;
  logic out_vld_q;
  out_item_t out_q;

  logic out_free;   // the result register can take a new value this cycle
  logic fire;       // the held tick is processed at this edge
  logic in_xfer;

  assign out_free = !out_vld_q || out_o.ready;
  assign fire     = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || fire;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      echo_q <= in_i.echo_level;
    end
  end

  // Per-tick state update: the sequencer and the tone generator advance
  // together whenever a held tick is processed.
  ctrl_res_t  ctrl_res;
  logic [2:0] band_next;
  logic       tone_lvl;

  urt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .echo_i (echo_q),
    .cfg_i  (cfg_q),
    .res_o  (ctrl_res),
    .band_o (band_next)
  );

  urt_tone u_tone (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .band_i (band_next),
    .tone_o (tone_lvl)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.trigger_out <= ctrl_res.trigger_out;
      out_q.tone_out    <= tone_lvl;
      out_q.width_valid <= ctrl_res.width_valid;
      out_q.echo_width  <= ctrl_res.echo_width;
      out_q.note_index  <= ctrl_res.note_index;
      out_q.timed_out   <= ctrl_res.timed_out;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.trigger_out = out_q.trigger_out;
  assign out_o.tone_out    = out_q.tone_out;
  assign out_o.width_valid = out_q.width_valid;
  assign out_o.echo_width  = out_q.echo_width;
  assign out_o.note_index  = out_q.note_index;
  assign out_o.timed_out   = out_q.timed_out;

`include "ultrasonic_ranger_tone_unit_assert.svh"

  `URT_ASSERT_NXT(a_held_tick_kept, in_vld_q && !out_free, in_vld_q, "held tick lost")
  `URT_ASSERT_NXT(a_fire_fills_output, fire, out_vld_q, "processed tick gave no result")
  `URT_ASSERT_IMP(a_ready_when_empty, !in_vld_q, in_i.ready, "input blocked while empty")

endmodule
